### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the roulette wheel selection block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RWS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RWS_ASSERT(label, clk, rst_n, prop, msg)
`define RWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### src/rws_pkg.sv
// ----------------------------------------------------------------------------
// rws_pkg
// Field widths, command codes and defaults of the roulette wheel selection.
// ----------------------------------------------------------------------------
`default_nettype none

package rws_pkg;

    localparam int LEVEL_W     = 17;
    localparam int IDX_FIELD_W = 6;
    localparam int CFG_W       = 7;

    localparam int DEF_MAX_ENTRIES   = 64;
    localparam int DEF_FRACTION_BITS = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

endpackage

`default_nettype wire

### src/rws_table.sv
// ----------------------------------------------------------------------------
// rws_table
// Cumulative probability table: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rws_table #(
    parameter int MAX_ENTRIES = rws_pkg::DEF_MAX_ENTRIES
) (
    input  wire logic                               clk,
    input  wire logic                               wr_en,
    input  wire logic [$clog2(MAX_ENTRIES)-1:0]     wr_addr,
    input  wire logic [rws_pkg::LEVEL_W-1:0]        wr_data,
    input  wire logic [$clog2(MAX_ENTRIES)-1:0]     rd_addr,
    output logic      [rws_pkg::LEVEL_W-1:0]        rd_data
);

    logic [rws_pkg::LEVEL_W-1:0] mem [MAX_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### src/roulette_wheel_select_top.sv
// ----------------------------------------------------------------------------
// roulette_wheel_select_top
// Roulette wheel selection over a table of cumulative probabilities.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  in        sink       in_valid / in_stall   cmd, entry_index, level
//  out       source     out_valid / out_stall selected_index, out_of_range
//  cfg       sink       cfg_valid / cfg_ready cfg_data (entries_in_use)
//
//  A write item and an out-of-range draw are handled in S_IDLE without leaving it.
//  A select item first compares the draw with the second-to-last entry, then
//  scans the table one entry a cycle from entry 0 to an entry not below the draw.
//  A draw above the second-to-last entry and not below entry 0 picks the last index.
//  Reset clears the control state only; the table is undefined until written.
//  A waiting result stalls a new item only while the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module roulette_wheel_select_top #(
    parameter int MAX_ENTRIES   = rws_pkg::DEF_MAX_ENTRIES,
    parameter int FRACTION_BITS = rws_pkg::DEF_FRACTION_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                cmd,
    input  wire logic [rws_pkg::IDX_FIELD_W-1:0]     entry_index,
    input  wire logic [rws_pkg::LEVEL_W-1:0]         level,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic      [rws_pkg::IDX_FIELD_W-1:0]     selected_index,
    output logic                                     out_of_range,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rws_pkg::CFG_W-1:0]           cfg_data
);

`include "assert_macros.svh"

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (rws_pkg::CFG_W > CNT_W) ? rws_pkg::CFG_W : CNT_W;
    localparam int EW    = (rws_pkg::IDX_FIELD_W > CNT_W) ? rws_pkg::IDX_FIELD_W : CNT_W;
    localparam int OW    = (FRACTION_BITS + 1 > rws_pkg::LEVEL_W) ?
                           FRACTION_BITS + 1 : rws_pkg::LEVEL_W;

    localparam logic [CMP_W-1:0] CMP_MAX   = CMP_W'(MAX_ENTRIES);
    localparam logic [CMP_W-1:0] CMP_TWO   = CMP_W'(2);
    localparam logic [EW-1:0]    EXT_MAX   = EW'(MAX_ENTRIES);
    localparam logic [OW-1:0]    ONE_LEVEL = OW'(1) << FRACTION_BITS;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LAST = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    logic [rws_pkg::CFG_W-1:0]     count_reg;
    logic [rws_pkg::LEVEL_W-1:0]   draw_reg, draw_next;
    logic [IDX_W-1:0]              scan_reg, scan_next;
    logic [IDX_W-1:0]              res_idx_reg, res_idx_next;
    logic                          above_reg, above_next;
    logic                          out_valid_reg, out_valid_next;
    logic [rws_pkg::IDX_FIELD_W-1:0] sel_reg, sel_next;
    logic                          oor_reg, oor_next;

    logic [CMP_W-1:0]              count_ext;
    logic [CNT_W-1:0]              count_clamped;
    logic [IDX_W-1:0]              last_idx;
    logic [IDX_W-1:0]              probe_idx;
    logic                          in_accept;
    logic                          out_free;
    logic                          draw_oor;
    logic                          wr_en;
    logic [IDX_W-1:0]              rd_addr;
    logic [rws_pkg::LEVEL_W-1:0]   rd_data;

    always_comb
    begin
        count_ext = CMP_W'(count_reg);
        priority if (count_ext < CMP_TWO)
        begin
            count_clamped = CNT_W'(CMP_TWO);
        end
        else if (count_ext > CMP_MAX)
        begin
            count_clamped = CNT_W'(CMP_MAX);
        end
        else
        begin
            count_clamped = CNT_W'(count_ext);
        end
    end

    assign last_idx  = IDX_W'(count_clamped - CNT_W'(1));
    assign probe_idx = IDX_W'(count_clamped - CNT_W'(2));

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;
    assign draw_oor  = OW'(level) > ONE_LEVEL;
    assign wr_en     = in_accept && (cmd == rws_pkg::CMD_WRITE) &&
                       (EW'(entry_index) < EXT_MAX);

    assign cfg_ready = 1'b1;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  rd_addr = probe_idx;
            S_LAST:  rd_addr = '0;
            S_SCAN:  rd_addr = scan_reg + 1'b1;
            S_DONE:  rd_addr = '0;
            default: rd_addr = '0;
        endcase
    end

    rws_table #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (IDX_W'(entry_index)),
        .wr_data (level),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        draw_next      = draw_reg;
        scan_next      = scan_reg;
        res_idx_next   = res_idx_reg;
        above_next     = above_reg;
        out_valid_next = out_valid_reg;
        sel_next       = sel_reg;
        oor_next       = oor_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (cmd == rws_pkg::CMD_SELECT))
                begin
                    if (draw_oor)
                    begin
                        out_valid_next = 1'b1;
                        sel_next       = '0;
                        oor_next       = 1'b1;
                    end
                    else
                    begin
                        draw_next  = level;
                        state_next = S_LAST;
                    end
                end
            end
            S_LAST:
            begin
                above_next = (draw_reg > rd_data);
                scan_next  = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                priority if (above_reg && (draw_reg >= rd_data))
                begin
                    res_idx_next = last_idx;
                    state_next   = S_DONE;
                end
                else if (rd_data >= draw_reg)
                begin
                    res_idx_next = scan_reg;
                    state_next   = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    sel_next       = rws_pkg::IDX_FIELD_W'(res_idx_reg);
                    oor_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= rws_pkg::CFG_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        draw_reg    <= draw_next;
        scan_reg    <= scan_next;
        res_idx_reg <= res_idx_next;
        above_reg   <= above_next;
        sel_reg     <= sel_next;
        oor_reg     <= oor_next;
    end

    assign out_valid      = out_valid_reg;
    assign selected_index = sel_reg;
    assign out_of_range   = oor_reg;

    `RWS_ASSERT(a_scan_bound, clk, rst_n,
        (state_reg != S_SCAN) || (scan_reg <= probe_idx),
        "scan ran past the second-to-last entry")
    `RWS_ASSERT_NEXT(a_last_pick, clk, rst_n,
        (state_reg == S_SCAN) && above_reg && (draw_reg >= rd_data),
        (state_reg == S_DONE) && (res_idx_reg == $past(last_idx)),
        "draw above the second-to-last entry did not pick the last index")
    `RWS_ASSERT_NEXT(a_scan_hit, clk, rst_n,
        (state_reg == S_SCAN) && !above_reg && (rd_data >= draw_reg),
        (state_reg == S_DONE) && (res_idx_reg == $past(scan_reg)),
        "scan hit did not record its index")

endmodule

`default_nettype wire
